@@ rtl/ebm_pkg.sv @@
// Shared types, command codes, state encoding and defaults for the extent bitmap allocator.
package ebm_pkg;

    // Default map size in extents
    localparam int NUM_EXTENTS_DEF = 1024;

    // Bitmap word width used by the scan unit and the map memory
    localparam int WORD_W = 64;
    localparam int POS_W  = 6;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic REG_BASE_EXTENT = 1'b0;

    // Input transfer payload
    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] extent_index;
    } in_t;

    // Output transfer payload
    typedef struct packed {
        logic [31:0] extent_number;
        logic        found;
        logic        is_full;
    } out_t;

    // Result of the find-first-set unit
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } ffs_res_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_OUT
    } state_t;

endpackage

@@ rtl/ebm_map_ram.sv @@
// Bitmap word memory: one write port, one read port with registered read data.
module ebm_map_ram #(
    parameter int WORDS = 16,
    parameter int AW    = 4
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [ebm_pkg::WORD_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [ebm_pkg::WORD_W-1:0]  rdata
);

    logic [ebm_pkg::WORD_W-1:0] mem [WORDS];
    logic [ebm_pkg::WORD_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ebm_ffs.sv @@
// Find-first-set unit: lowest set bit of one bitmap word at or above a lower bound.
module ebm_ffs (
    input  logic [ebm_pkg::WORD_W-1:0] word,
    input  logic [ebm_pkg::POS_W-1:0]  lo,
    output ebm_pkg::ffs_res_t          res
);

    logic [ebm_pkg::WORD_W-1:0] masked;

    // Drop bits below the lower bound
    assign masked = word & ({ebm_pkg::WORD_W{1'b1}} << lo);

    // Priority encode, lowest bit wins
    always_comb
    begin
        res.hit = |masked;
        res.pos = '0;
        for (int i = ebm_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                res.pos = ebm_pkg::POS_W'(i);
            end
        end
    end

endmodule

@@ rtl/extent_bitmap_allocator_top.sv @@
// Next-fit extent allocator over a free bitmap (set bit = free), one command at a time.
// After reset the map memory is filled by a sweep over every word during which no command is
// taken; configuration writes work throughout. The map is held as 64-bit words in a memory
// with one read and one write port, and a single find-first-set unit checks one word per
// cycle. Allocate reads the remembered start word, then checks words in order, each with
// the following word fetched ahead, up to the first free bit or the last word, and then
// offers the result. Free reads the word, writes it back with the bit set and then offers
// the result; query and an out-of-range free offer the result directly. The result is held
// until the output transfer, and the next command is taken the cycle after that.
module extent_bitmap_allocator_top #(
    parameter int NUM_EXTENTS = ebm_pkg::NUM_EXTENTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    // command channel
    input  logic           in_valid,
    output logic           in_stall,
    input  ebm_pkg::in_t   in_data,
    // result channel
    output logic           out_valid,
    input  logic           out_stall,
    output ebm_pkg::out_t  out_data,
    // configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int IW    = ($clog2(NUM_EXTENTS) > ebm_pkg::POS_W) ?
                           $clog2(NUM_EXTENTS) : (ebm_pkg::POS_W + 1);
    localparam int AW    = IW - ebm_pkg::POS_W;
    localparam int WORDS = (NUM_EXTENTS + ebm_pkg::WORD_W - 1) / ebm_pkg::WORD_W;
    localparam int TAIL  = NUM_EXTENTS % ebm_pkg::WORD_W;
    localparam logic [ebm_pkg::WORD_W-1:0] LAST_MASK = (TAIL == 0) ?
        {ebm_pkg::WORD_W{1'b1}} : ((ebm_pkg::WORD_W'(1) << TAIL) - ebm_pkg::WORD_W'(1));
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_EXTENTS - 1);

    ebm_pkg::state_t state_reg, state_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   start_reg, start_next;
    logic [AW-1:0]   word_reg, word_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            first_reg, first_next;
    logic            last_free_reg, last_free_next;
    logic [31:0]     base_reg;
    ebm_pkg::out_t   out_reg, out_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ebm_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ebm_pkg::WORD_W-1:0] ram_rdata;

    logic [ebm_pkg::POS_W-1:0]  scan_lo;
    ebm_pkg::ffs_res_t          scan_res;
    logic [IW-1:0]              hit_idx;
    logic                       in_range;
    logic                       cfg_wr;

    // Map memory
    ebm_map_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Single find-first-set unit
    assign scan_lo = first_reg ? start_reg[ebm_pkg::POS_W-1:0] : '0;

    ebm_ffs u_ffs (
        .word (ram_rdata),
        .lo   (scan_lo),
        .res  (scan_res)
    );

    assign hit_idx  = {word_reg, scan_res.pos};
    assign in_range = (17'(in_data.extent_index) < 17'(NUM_EXTENTS));

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == ebm_pkg::REG_BASE_EXTENT) ? base_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'd0;
        end
        else if (cfg_wr && (paddr[2] == ebm_pkg::REG_BASE_EXTENT))
        begin
            base_reg <= pwdata;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ebm_pkg::ST_CLEAR;
            start_reg     <= '0;
            clr_reg       <= '0;
            last_free_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            clr_reg       <= clr_next;
            last_free_reg <= last_free_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        word_reg  <= word_next;
        first_reg <= first_next;
        out_reg   <= out_next;
    end

    // Next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        word_next      = word_reg;
        clr_next       = clr_reg;
        first_next     = first_reg;
        last_free_next = last_free_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = '0;
        ram_raddr      = word_reg;

        case (state_reg)
            ebm_pkg::ST_CLEAR:
            begin
                // fill every word as free, padding bits of the tail word stay clear
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == LAST_WORD) ? LAST_MASK : {ebm_pkg::WORD_W{1'b1}};
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ebm_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ebm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_data.cmd;
                    idx_next = IW'(in_data.extent_index);
                    case (in_data.cmd)
                        ebm_pkg::CMD_ALLOC:
                        begin
                            word_next  = start_reg[IW-1:ebm_pkg::POS_W];
                            first_next = 1'b1;
                            state_next = ebm_pkg::ST_SCAN_RD;
                        end
                        ebm_pkg::CMD_FREE:
                        begin
                            if (in_range)
                            begin
                                state_next = ebm_pkg::ST_FREE_RD;
                            end
                            else
                            begin
                                out_next   = '{extent_number: 32'd0, found: 1'b0,
                                               is_full: !last_free_reg};
                                state_next = ebm_pkg::ST_OUT;
                            end
                        end
                        default:
                        begin
                            out_next   = '{extent_number: 32'd0, found: 1'b0,
                                           is_full: !last_free_reg};
                            state_next = ebm_pkg::ST_OUT;
                        end
                    endcase
                end
            end

            ebm_pkg::ST_SCAN_RD:
            begin
                ram_raddr  = word_reg;
                state_next = ebm_pkg::ST_SCAN_CHK;
            end

            ebm_pkg::ST_SCAN_CHK:
            begin
                // fetch the following word ahead while this one is checked
                ram_raddr = word_reg + AW'(1);
                if (scan_res.hit)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = word_reg;
                    ram_wdata  = ram_rdata & ~(ebm_pkg::WORD_W'(1) << scan_res.pos);
                    start_next = hit_idx;
                    if (hit_idx == LAST_IDX)
                    begin
                        last_free_next = 1'b0;
                    end
                    out_next   = '{extent_number: base_reg + 32'(hit_idx), found: 1'b1,
                                   is_full: !last_free_next};
                    state_next = ebm_pkg::ST_OUT;
                end
                else if (word_reg == LAST_WORD)
                begin
                    out_next   = '{extent_number: 32'd0, found: 1'b0,
                                   is_full: !last_free_reg};
                    state_next = ebm_pkg::ST_OUT;
                end
                else
                begin
                    word_next  = word_reg + AW'(1);
                    first_next = 1'b0;
                end
            end

            ebm_pkg::ST_FREE_RD:
            begin
                ram_raddr  = idx_reg[IW-1:ebm_pkg::POS_W];
                state_next = ebm_pkg::ST_FREE_WR;
            end

            ebm_pkg::ST_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IW-1:ebm_pkg::POS_W];
                ram_wdata = ram_rdata |
                            (ebm_pkg::WORD_W'(1) << idx_reg[ebm_pkg::POS_W-1:0]);
                if (idx_reg == LAST_IDX)
                begin
                    last_free_next = 1'b1;
                end
                out_next   = '{extent_number: 32'd0, found: 1'b1,
                               is_full: !last_free_next};
                state_next = ebm_pkg::ST_OUT;
            end

            ebm_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ebm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ebm_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    assign in_stall  = (state_reg != ebm_pkg::ST_IDLE);
    assign out_valid = (state_reg == ebm_pkg::ST_OUT);
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result dropped or changed");

    // A result that is not found carries extent number zero
    a_zero_number: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.extent_number == 32'd0))
        else $error("nonzero extent number without a hit");

    // Query never reports found
    a_query_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cmd_reg == ebm_pkg::CMD_QUERY)) |-> !out_data.found)
        else $error("query reported found");

    // Full flag matches the tracked state of the last entry
    a_full_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.is_full == !last_free_reg))
        else $error("is_full disagrees with last entry state");
`endif

endmodule

@@ tb/sv/ebm_result_checker.sv @@
// Result checker for the extent bitmap allocator: tracks the map, predicts and compares.
`timescale 1ns / 1ps

module ebm_result_checker #(
    parameter int NUM_EXTENTS = ebm_pkg::NUM_EXTENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  ebm_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  ebm_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            errors,
    output int            outstanding
);

    // shadow of the allocator state
    logic [NUM_EXTENTS-1:0] free_bits;
    logic [9:0]             scan_from;
    logic [31:0]            base_reg;

    // results owed by the block, oldest first
    ebm_pkg::out_t owed_results[$];

    // apply one command to the shadow map and return the result it must produce
    function automatic ebm_pkg::out_t apply_command(input ebm_pkg::in_t item);
        ebm_pkg::out_t res;
        int            j;
        res = '0;
        if (item.cmd == ebm_pkg::CMD_ALLOC)
        begin
            for (j = int'(scan_from); j < NUM_EXTENTS; j++)
            begin
                if (free_bits[j])
                begin
                    free_bits[j]      = 1'b0;
                    scan_from         = 10'(j);
                    res.extent_number = base_reg + 32'(j);
                    res.found         = 1'b1;
                    break;
                end
            end
        end
        else if (item.cmd == ebm_pkg::CMD_FREE)
        begin
            // out-of-range index leaves the map alone and reports not found
            if (int'(item.extent_index) < NUM_EXTENTS)
            begin
                free_bits[item.extent_index] = 1'b1;
                res.found = 1'b1;
            end
        end
        res.is_full = ~free_bits[NUM_EXTENTS-1];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ebm_pkg::out_t exp_res;
        if (!rst_n)
        begin
            free_bits = '1;
            scan_from = '0;
            base_reg  = '0;
            owed_results.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            // register write completes
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 &&
                paddr[2] == ebm_pkg::REG_BASE_EXTENT)
                base_reg = pwdata;

            // result transfer: compare against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result: extent_number %0d found %0d is_full %0d",
                           out_data.extent_number, out_data.found, out_data.is_full);
                    errors++;
                end
                else
                begin
                    exp_res = owed_results.pop_front();
                    if (out_data.extent_number !== exp_res.extent_number)
                    begin
                        $error("extent_number: expected %0d, got %0d",
                               exp_res.extent_number, out_data.extent_number);
                        errors++;
                    end
                    if (out_data.found !== exp_res.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_res.found, out_data.found);
                        errors++;
                    end
                    if (out_data.is_full !== exp_res.is_full)
                    begin
                        $error("is_full: expected %0d, got %0d",
                               exp_res.is_full, out_data.is_full);
                        errors++;
                    end
                end
            end

            // command transfer: predict its result and queue it last
            if (in_valid && !in_stall)
                owed_results.insert(owed_results.size(), apply_command(in_data));

            outstanding = owed_results.size();
        end
    end

endmodule

@@ tb/sv/tb_extent_bitmap_allocator_top.sv @@
// Testbench top for the extent bitmap allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_extent_bitmap_allocator_top;

    localparam int         MAP_SIZE    = ebm_pkg::NUM_EXTENTS_DEF;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         LONG_HOLD   = 400;
    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam logic [2:0] BASE_ADDR   = {ebm_pkg::REG_BASE_EXTENT, 2'b00};

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    ebm_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_stall;
    ebm_pkg::out_t out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int errors;
    int outstanding;
    int cycle_count;
    int alloc_mark;
    bit idle_en;
    bit hold_req;

    extent_bitmap_allocator_top #(
        .NUM_EXTENTS(MAP_SIZE)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ebm_result_checker #(
        .NUM_EXTENTS(MAP_SIZE)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .outstanding(outstanding)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one command and hold it until the transfer
    task automatic send_cmd(input logic [1:0] cmd, input logic [9:0] idx);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid             <= 1'b1;
        in_data.cmd          <= cmd;
        in_data.extent_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait for every owed result
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // register write: setup then access
    task automatic write_base(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random command mix; near frees land just behind the allocation front,
    // tail mode aims frees at the top of the map to toggle full
    task automatic run_mix(input int count, input int alloc_pct, input int near_pct,
                           input int wide_pct, input bit tail_mode, input bit allow_idle,
                           input int hold_at);
        int         roll;
        int         near;
        logic [1:0] cmd;
        logic [9:0] idx;
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                idle_en = allow_idle && ($urandom_range(0, 9) < 7);
            if (n == hold_at)
                hold_req = 1'b1;
            roll = $urandom_range(0, 99);
            idx  = 10'($urandom_range(0, 1023));
            if (roll < alloc_pct)
            begin
                cmd = ebm_pkg::CMD_ALLOC;
                if (alloc_mark < MAP_SIZE - 1)
                    alloc_mark++;
            end
            else if (roll < alloc_pct + near_pct)
            begin
                cmd = ebm_pkg::CMD_FREE;
                if (tail_mode)
                    idx = ($urandom_range(0, 2) == 0) ? 10'(MAP_SIZE - 1)
                                                      : 10'($urandom_range(1000, 1022));
                else
                begin
                    near = alloc_mark - int'($urandom_range(0, 24));
                    idx  = 10'((near < 0) ? 0 : near);
                end
            end
            else if (roll < alloc_pct + near_pct + wide_pct)
                cmd = ebm_pkg::CMD_FREE;
            else
                cmd = ($urandom_range(0, 1) == 0) ? ebm_pkg::CMD_QUERY : CMD_SPARE;
            send_cmd(cmd, idx);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_en    = 1'b0;
        hold_req   = 1'b0;
        alloc_mark = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty map, allocation at index 0 with zero base, reuse, double free
        write_base(32'h0000_0000);
        send_cmd(ebm_pkg::CMD_QUERY, 10'h000);
        send_cmd(CMD_SPARE, 10'h3FF);
        send_cmd(ebm_pkg::CMD_ALLOC, 10'h3FF);
        send_cmd(ebm_pkg::CMD_ALLOC, 10'h000);
        send_cmd(ebm_pkg::CMD_FREE, 10'h000);    // below the scan start, never seen again
        send_cmd(ebm_pkg::CMD_ALLOC, 10'h155);
        send_cmd(ebm_pkg::CMD_FREE, 10'h002);    // frees the scan start itself
        send_cmd(ebm_pkg::CMD_ALLOC, 10'h2AA);
        send_cmd(ebm_pkg::CMD_FREE, 10'h3FF);    // already free
        send_cmd(ebm_pkg::CMD_FREE, 10'h2AA);
        send_cmd(ebm_pkg::CMD_FREE, 10'h155);
        send_cmd(ebm_pkg::CMD_FREE, 10'h000);
        drain();

        // largest base: sums wrap past 2^32
        write_base(32'hFFFF_FFFF);
        send_cmd(ebm_pkg::CMD_ALLOC, 10'h000);
        send_cmd(ebm_pkg::CMD_ALLOC, 10'h3FF);
        send_cmd(ebm_pkg::CMD_QUERY, 10'h3FF);
        alloc_mark = 5;

        // mixed traffic with one long result hold-off
        run_mix(600, 45, 25, 15, 1'b0, 1'b1, 300);
        drain();

        // mostly allocations to push the front toward the end of the map
        write_base($urandom);
        run_mix(850, 94, 4, 1, 1'b0, 1'b1, -1);
        drain();

        // map end: failed allocations, full flag toggling, no idling at the very end
        write_base(32'hFFFF_FE00);
        run_mix(300, 40, 35, 10, 1'b1, 1'b1, -1);
        run_mix(200, 40, 35, 10, 1'b1, 1'b0, -1);
        drain();

        repeat (40) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
